[hdl/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// ptt_pkg
// shared types, codes and width helpers for the periodic timer table
// ----------------------------------------------------------------------------
package ptt_pkg;

  // defaults for the top-level parameters
  localparam int NUM_SLOTS_DEF = 16;
  localparam int TICK_BITS_DEF = 32;

  // fixed port widths
  localparam int OP_W       = 2;
  localparam int IN_TICK_W  = 32;
  localparam int IDENT_W    = 8;
  localparam int IN_SLOT_W  = 4;
  localparam int OUT_SLOT_W = 4;
  localparam int KIND_W     = 2;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // operation codes on in_op
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  // classified work item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD,
    KIND_REMOVE,
    KIND_CHECK
  } kind_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ADD,
    BK_CHECK
  } back_state_t;

  // slot index width, at least one bit
  function automatic int slot_w(input int num_slots);
    return (num_slots > 1) ? $clog2(num_slots) : 1;
  endfunction

  // packed width of one queued work item
  function automatic int item_w(input int tick_bits, input int slot_bits);
    return KIND_W + 3 * tick_bits + 2 + IDENT_W + slot_bits;
  endfunction

endpackage

[hdl/ptt_ram.sv]
// ----------------------------------------------------------------------------
// ptt_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/ptt_queue.sv]
// ----------------------------------------------------------------------------
// ptt_queue
// short register queue that decouples item intake from execution
// ----------------------------------------------------------------------------
module ptt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ptt_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

endmodule

[hdl/ptt_front.sv]
// ----------------------------------------------------------------------------
// ptt_front
// accepts commands, decodes the op and precomputes the add deadline
// ----------------------------------------------------------------------------
module ptt_front #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF,
  parameter int TICK_BITS = ptt_pkg::TICK_BITS_DEF,
  localparam int SLOT_W = ptt_pkg::slot_w(NUM_SLOTS),
  localparam int ITEM_W = ptt_pkg::item_w(TICK_BITS, SLOT_W)
) (
  input  logic                           start,
  output logic                           busy,
  input  logic [ptt_pkg::OP_W-1:0]       in_op,
  input  logic [ptt_pkg::IN_TICK_W-1:0]  in_now,
  input  logic [ptt_pkg::IN_TICK_W-1:0]  in_delay,
  input  logic                           in_one_shot,
  input  logic [ptt_pkg::IDENT_W-1:0]    in_callback_id,
  input  logic [ptt_pkg::IN_SLOT_W-1:0]  in_slot,
  input  logic                           queue_full,
  output logic                           push,
  output logic [ITEM_W-1:0]              push_data
);

  typedef struct packed {
    ptt_pkg::kind_t                kind;
    logic [TICK_BITS-1:0]          tick;
    logic [TICK_BITS-1:0]          period;
    logic [TICK_BITS-1:0]          dl;
    logic                          carry;
    logic                          once;
    logic [ptt_pkg::IDENT_W-1:0]   ident;
    logic [SLOT_W-1:0]             slot;
  } item_t;

  logic [TICK_BITS-1:0] tick;
  logic [TICK_BITS-1:0] period;
  logic [TICK_BITS:0]   sum;
  logic                 keep;
  item_t                item;

  // ticks are taken modulo the tick width
  assign tick   = TICK_BITS'(in_now);
  assign period = TICK_BITS'(in_delay);
  // carry out means the deadline wrapped past the end of the tick range
  assign sum    = {1'b0, tick} + {1'b0, period};

  always_comb begin
    item        = '0;
    item.tick   = tick;
    item.period = period;
    item.dl     = sum[TICK_BITS-1:0];
    item.carry  = sum[TICK_BITS];
    item.once   = in_one_shot;
    item.ident  = in_callback_id;
    item.slot   = SLOT_W'(in_slot);
    keep        = 1'b0;
    unique case (in_op)
      ptt_pkg::OP_ADD: begin
        item.kind = ptt_pkg::KIND_ADD;
        keep      = 1'b1;
      end
      ptt_pkg::OP_REMOVE: begin
        // a slot beyond the table is a no-op
        item.kind = ptt_pkg::KIND_REMOVE;
        keep      = (32'(in_slot) < NUM_SLOTS);
      end
      ptt_pkg::OP_CHECK: begin
        item.kind = ptt_pkg::KIND_CHECK;
        keep      = 1'b1;
      end
      default: begin
        item.kind = ptt_pkg::KIND_ADD;
        keep      = 1'b0;
      end
    endcase
  end

  assign busy      = queue_full;
  assign push      = start && !queue_full && keep;
  assign push_data = item;

endmodule

[hdl/ptt_back.sv]
// ----------------------------------------------------------------------------
// ptt_back
// executes queued items: slot scan for add, remove, and the expiry walk
// ----------------------------------------------------------------------------
module ptt_back #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF,
  parameter int TICK_BITS = ptt_pkg::TICK_BITS_DEF,
  localparam int SLOT_W = ptt_pkg::slot_w(NUM_SLOTS),
  localparam int ITEM_W = ptt_pkg::item_w(TICK_BITS, SLOT_W)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  logic [ITEM_W-1:0]               q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  output logic                            out_fired,
  output logic [ptt_pkg::IDENT_W-1:0]     out_fired_id,
  output logic [ptt_pkg::OUT_SLOT_W-1:0]  out_slot_index,
  output logic                            out_table_full,
  output logic                            out_last
);

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int OSW   = ptt_pkg::OUT_SLOT_W;
  localparam int IDW   = ptt_pkg::IDENT_W;

  typedef struct packed {
    ptt_pkg::kind_t        kind;
    logic [TICK_BITS-1:0]  tick;
    logic [TICK_BITS-1:0]  period;
    logic [TICK_BITS-1:0]  dl;
    logic                  carry;
    logic                  once;
    logic [IDW-1:0]        ident;
    logic [SLOT_W-1:0]     slot;
  } item_t;

  typedef struct packed {
    logic [TICK_BITS-1:0]  dl;
    logic [TICK_BITS-1:0]  period;
    logic                  once;
    logic [IDW-1:0]        ident;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  ptt_pkg::back_state_t state_r, state_nxt;

  item_t                 q_item;
  item_t                 cur_r;
  logic                  load_cur;
  logic                  wrap_r, wrap_nxt;
  logic [TICK_BITS-1:0]  prev_old_r, prev_old_nxt;
  logic [TICK_BITS-1:0]  prev_tick_r, prev_tick_nxt;
  logic [NUM_SLOTS-1:0]  busy_r, busy_nxt;
  logic [NUM_SLOTS-1:0]  wrapped_r, wrapped_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [SLOT_W-1:0]     idx_lo;
  logic                  idx_end;
  logic                  ev_v_r, ev_v_nxt;
  logic [SLOT_W-1:0]     ev_idx_r, ev_idx_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [IDW-1:0]        pend_id_r, pend_id_nxt;
  logic [SLOT_W-1:0]     pend_slot_r, pend_slot_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_fired_r, out_fired_nxt;
  logic [IDW-1:0]        out_id_r, out_id_nxt;
  logic [OSW-1:0]        out_slot_r, out_slot_nxt;
  logic                  out_full_r, out_full_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [ENT_W-1:0]      ram_rdata;

  entry_t                ent;
  entry_t                add_entry;
  entry_t                reload_entry;
  logic [TICK_BITS:0]    reload_sum;
  logic                  live;
  logic                  hit;

  assign q_item  = item_t'(q_data);
  assign idx_lo  = idx_r[SLOT_W-1:0];
  assign idx_end = (idx_r == CNT_W'(NUM_SLOTS));

  // deadline, period, mode and id per slot
  ptt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_ptt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_lo),
    .rdata (ram_rdata)
  );

  assign ent = entry_t'(ram_rdata);

  assign add_entry = '{dl: cur_r.dl, period: cur_r.period, once: cur_r.once,
                       ident: cur_r.ident};

  // periodic reload: new deadline from the check tick, carry is the wrap mark
  assign reload_sum   = {1'b0, cur_r.tick} + {1'b0, ent.period};
  assign reload_entry = '{dl: reload_sum[TICK_BITS-1:0], period: ent.period,
                          once: 1'b0, ident: ent.ident};

  assign live = busy_r[ev_idx_r] && !wrapped_r[ev_idx_r];
  assign hit  = live && ((ent.dl <= cur_r.tick) ||
                         (wrap_r && (prev_old_r <= ent.dl)));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptt_pkg::BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_item.kind)
            ptt_pkg::KIND_ADD:   state_nxt = ptt_pkg::BK_ADD;
            ptt_pkg::KIND_CHECK: state_nxt = ptt_pkg::BK_CHECK;
            default:             state_nxt = ptt_pkg::BK_IDLE;
          endcase
        end
      end
      ptt_pkg::BK_ADD: begin
        if (idx_end || !busy_r[idx_lo]) begin
          state_nxt = ptt_pkg::BK_IDLE;
        end
      end
      ptt_pkg::BK_CHECK: begin
        if (idx_end && !ev_v_r) begin
          state_nxt = ptt_pkg::BK_IDLE;
        end
      end
      default: state_nxt = ptt_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop         = 1'b0;
    load_cur      = 1'b0;
    wrap_nxt      = wrap_r;
    prev_old_nxt  = prev_old_r;
    prev_tick_nxt = prev_tick_r;
    busy_nxt      = busy_r;
    wrapped_nxt   = wrapped_r;
    idx_nxt       = idx_r;
    ev_v_nxt      = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    pend_slot_nxt = pend_slot_r;
    out_valid_nxt = 1'b0;
    out_fired_nxt = 1'b0;
    out_id_nxt    = '0;
    out_slot_nxt  = '0;
    out_full_nxt  = 1'b0;
    out_last_nxt  = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ev_idx_r;
    ram_wdata     = reload_entry;
    ram_re        = 1'b0;
    unique case (state_r)
      ptt_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          load_cur   = 1'b1;
          idx_nxt    = '0;
          pend_v_nxt = 1'b0;
          unique case (q_item.kind)
            ptt_pkg::KIND_REMOVE: busy_nxt[q_item.slot] = 1'b0;
            ptt_pkg::KIND_CHECK: begin
              wrap_nxt      = (q_item.tick < prev_tick_r);
              prev_old_nxt  = prev_tick_r;
              prev_tick_nxt = q_item.tick;
              if (q_item.tick < prev_tick_r) begin
                wrapped_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ptt_pkg::BK_ADD: begin
        if (idx_end) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = 1'b1;
          out_last_nxt  = 1'b1;
        end else if (!busy_r[idx_lo]) begin
          ram_we               = 1'b1;
          ram_waddr            = idx_lo;
          ram_wdata            = add_entry;
          busy_nxt[idx_lo]     = 1'b1;
          wrapped_nxt[idx_lo]  = cur_r.carry;
          out_valid_nxt        = 1'b1;
          out_slot_nxt         = OSW'(idx_lo);
          out_last_nxt         = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ptt_pkg::BK_CHECK: begin
        if (!idx_end) begin
          ram_re     = 1'b1;
          idx_nxt    = idx_r + 1'b1;
          ev_v_nxt   = 1'b1;
          ev_idx_nxt = idx_lo;
        end
        if (ev_v_r && hit) begin
          // older fired result goes out now, this one waits for its last flag
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_fired_nxt = 1'b1;
            out_id_nxt    = pend_id_r;
            out_slot_nxt  = OSW'(pend_slot_r);
          end
          pend_v_nxt    = 1'b1;
          pend_id_nxt   = ent.ident;
          pend_slot_nxt = ev_idx_r;
          if (ent.once) begin
            busy_nxt[ev_idx_r] = 1'b0;
          end else begin
            ram_we                = 1'b1;
            wrapped_nxt[ev_idx_r] = reload_sum[TICK_BITS];
          end
        end
        if (idx_end && !ev_v_r && pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = 1'b1;
          out_id_nxt    = pend_id_r;
          out_slot_nxt  = OSW'(pend_slot_r);
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptt_pkg::BK_IDLE;
      busy_r      <= '0;
      wrapped_r   <= '0;
      prev_tick_r <= '0;
      idx_r       <= '0;
      ev_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      wrapped_r   <= wrapped_nxt;
      prev_tick_r <= prev_tick_nxt;
      idx_r       <= idx_nxt;
      ev_v_r      <= ev_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cur) begin
      cur_r <= q_item;
    end
    wrap_r      <= wrap_nxt;
    prev_old_r  <= prev_old_nxt;
    ev_idx_r    <= ev_idx_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_fired_r <= out_fired_nxt;
    out_id_r    <= out_id_nxt;
    out_slot_r  <= out_slot_nxt;
    out_full_r  <= out_full_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_fired      = out_fired_r;
  assign out_fired_id   = out_id_r;
  assign out_slot_index = out_slot_r;
  assign out_table_full = out_full_r;
  assign out_last       = out_last_r;

endmodule

[hdl/periodic_timer_table.sv]
// add: after the start transfer, the back end scans upward from slot zero past the busy
//   slots and reports the first free one; a full table reports table_full instead
// flow: a check walks every slot, one slot per cycle through the slot memory read port;
//   a remove is done as the back end pops it; new items are popped only in idle; up to two items queue ahead
// reset: synchronous, active low; clears the queue, busy and wrapped marks and the last
//   checked tick; slot memory is not cleared, results are never stalled by the receiver
// ----------------------------------------------------------------------------
// periodic_timer_table
// table of one-shot and periodic timers on a wrapping tick, with slot walk
// ----------------------------------------------------------------------------
module periodic_timer_table #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF,
  parameter int TICK_BITS = ptt_pkg::TICK_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command channel: transfer when start is high and busy is low
  input  logic                            start,
  output logic                            busy,
  input  logic [ptt_pkg::OP_W-1:0]        in_op,
  input  logic [ptt_pkg::IN_TICK_W-1:0]   in_now,
  input  logic [ptt_pkg::IN_TICK_W-1:0]   in_delay,
  input  logic                            in_one_shot,
  input  logic [ptt_pkg::IDENT_W-1:0]     in_callback_id,
  input  logic [ptt_pkg::IN_SLOT_W-1:0]   in_slot,
  // result channel: one-cycle strobe, no back-pressure
  output logic                            out_valid,
  output logic                            out_fired,
  output logic [ptt_pkg::IDENT_W-1:0]     out_fired_id,
  output logic [ptt_pkg::OUT_SLOT_W-1:0]  out_slot_index,
  output logic                            out_table_full,
  output logic                            out_last
);

  localparam int SLOT_W = ptt_pkg::slot_w(NUM_SLOTS);
  localparam int ITEM_W = ptt_pkg::item_w(TICK_BITS, SLOT_W);

  // front to queue
  logic              push;
  logic [ITEM_W-1:0] push_data;
  logic              queue_full;

  // queue to back
  logic              q_pop;
  logic              q_empty;
  logic [ITEM_W-1:0] q_data;

  // decode, drop unused op codes and out-of-range removes,
  // precompute the add deadline and its wrap mark
  ptt_front #(
    .NUM_SLOTS (NUM_SLOTS),
    .TICK_BITS (TICK_BITS)
  ) u_ptt_front (
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_now         (in_now),
    .in_delay       (in_delay),
    .in_one_shot    (in_one_shot),
    .in_callback_id (in_callback_id),
    .in_slot        (in_slot),
    .queue_full     (queue_full),
    .push           (push),
    .push_data      (push_data)
  );

  // short queue so commands keep flowing while the back end walks slots
  ptt_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (ptt_pkg::QUEUE_DEPTH)
  ) u_ptt_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_data),
    .pop   (q_pop),
    .rdata (q_data),
    .full  (queue_full),
    .empty (q_empty)
  );

  // sequencer: lowest-free-slot scan for add, busy clear for remove, expiry walk for check;
  // a fired result is held until the next one fires or the walk ends, so the final one can carry last
  ptt_back #(
    .NUM_SLOTS (NUM_SLOTS),
    .TICK_BITS (TICK_BITS)
  ) u_ptt_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_fired      (out_fired),
    .out_fired_id   (out_fired_id),
    .out_slot_index (out_slot_index),
    .out_table_full (out_table_full),
    .out_last       (out_last)
  );

endmodule

[hdl/ptt_checker.sv]
// ----------------------------------------------------------------------------
// ptt_checker
// port-level checks on the result stream of the periodic timer table
// ----------------------------------------------------------------------------
module ptt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            busy,
  input logic                            out_valid,
  input logic                            out_fired,
  input logic [ptt_pkg::OUT_SLOT_W-1:0]  out_slot_index,
  input logic                            out_table_full,
  input logic                            out_last
);

  // a fired result never also flags a full table
  a_fired_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_fired && out_table_full))
    else $error("fired result also flags a full table");

  // a dropped add reports slot zero and ends its item
  a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> ((out_slot_index == '0) && out_last))
    else $error("table-full result with bad slot or last");

  // an add gives exactly one result
  a_add_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fired) |-> out_last)
    else $error("add result without last");

  // reset leaves no result strobe and an open command port
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("activity right after reset");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (.*);
